### design/pf_pkg.sv
package pf_pkg;

    localparam int SQ_SIDE     = 5;
    localparam int SQ_CELLS    = SQ_SIDE * SQ_SIDE;
    localparam int NUM_LETTERS = 26;
    localparam int LETTER_W    = 5;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [LETTER_W-1:0] t_cell;
    typedef logic [2:0]          t_rc;
    typedef logic [1:0]          t_kind;

    localparam t_kind KIND_KEY      = 2'd0;
    localparam t_kind KIND_KEY_END  = 2'd1;
    localparam t_kind KIND_TEXT     = 2'd2;
    localparam t_kind KIND_TEXT_END = 2'd3;

    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_X = 5'd23;

    localparam logic [7:0] ASCII_UA = 8'h41;
    localparam logic [7:0] ASCII_UZ = 8'h5a;
    localparam logic [7:0] ASCII_LA = 8'h61;
    localparam logic [7:0] ASCII_LZ = 8'h7a;

    typedef struct packed {
        logic    ok;
        t_letter idx;
    } t_fold;

    typedef struct packed {
        t_cell a;
        t_cell b;
    } t_cell_pair;

    // case fold, j merged into i
    function automatic t_fold fold_letter(input logic [7:0] ch);
        t_fold f;
        f.ok  = 1'b0;
        f.idx = '0;
        if (ch >= ASCII_LA && ch <= ASCII_LZ) begin
            f.ok  = 1'b1;
            f.idx = t_letter'(ch - ASCII_LA);
        end else if (ch >= ASCII_UA && ch <= ASCII_UZ) begin
            f.ok  = 1'b1;
            f.idx = t_letter'(ch - ASCII_UA);
        end
        if (f.idx == LETTER_J) begin
            f.idx = LETTER_I;
        end
        return f;
    endfunction

    function automatic t_rc cell_row(input t_cell p);
        t_rc r;
        if (p >= t_cell'(4 * SQ_SIDE)) begin
            r = 3'd4;
        end else if (p >= t_cell'(3 * SQ_SIDE)) begin
            r = 3'd3;
        end else if (p >= t_cell'(2 * SQ_SIDE)) begin
            r = 3'd2;
        end else if (p >= t_cell'(SQ_SIDE)) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic t_cell cell_at(input t_rc row, input t_rc col);
        return t_cell'(row) * t_cell'(SQ_SIDE) + t_cell'(col);
    endfunction

    function automatic t_rc cell_col(input t_cell p);
        t_cell base;
        base = cell_at(cell_row(p), 3'd0);
        return t_rc'(p - base);
    endfunction

    function automatic t_rc wrap_inc(input t_rc v);
        return (v == t_rc'(SQ_SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

### design/pf_ram.sv
module pf_ram #(
    parameter int Width = 5,
    parameter int Depth = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/pf_rule.sv
module pf_rule (
    input  pf_pkg::t_cell_pair i_pos,
    output pf_pkg::t_cell_pair o_cell
);

    import pf_pkg::*;

    t_rc r1;
    t_rc c1;
    t_rc r2;
    t_rc c2;

    always_comb begin
        r1 = cell_row(i_pos.a);
        c1 = cell_col(i_pos.a);
        r2 = cell_row(i_pos.b);
        c2 = cell_col(i_pos.b);
        if (r1 == r2) begin
            o_cell.a = cell_at(r1, wrap_inc(c1));
            o_cell.b = cell_at(r2, wrap_inc(c2));
        end else if (c1 == c2) begin
            o_cell.a = cell_at(wrap_inc(r1), c1);
            o_cell.b = cell_at(wrap_inc(r2), c2);
        end else begin
            // rectangle: swap columns
            o_cell.a = cell_at(r1, c2);
            o_cell.b = cell_at(r2, c1);
        end
    end

endmodule

### design/playfair_cipher_encrypt_top.sv
// channel   | valid        | ready        | payload
// ----------+--------------+--------------+------------------------------
// request   | i_in_valid   | o_in_ready   | i_kind, i_letter
// result    | o_out_valid  | i_out_ready  | o_cipher_letter, o_last
//
// a key letter is taken in idle; key end walks the 26 letters to fill the square.
// a text request that completes a pair passes the position and square rams
// (one read port each, registered) through the states rda, rdb, map, sq1 and sq2
// before the first letter shows, then the two letters go out one after the other;
// ready is low until both leave. other text requests leave the sequencer in idle.
// reset is synchronous: the square is empty and no letter waits.
// a stall on the result side holds the sequencer in place.
module playfair_cipher_encrypt_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pf_pkg::t_kind   i_kind,
    input  logic [7:0]      i_letter,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [6:0]      o_cipher_letter,
    output logic            o_last
);

    import pf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_RDB  = 3'd3;
    localparam logic [2:0] S_MAP  = 3'd4;
    localparam logic [2:0] S_SQ1  = 3'd5;
    localparam logic [2:0] S_SQ2  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]             r_state, n_state;
    logic [NUM_LETTERS-1:0] r_used, n_used;
    t_cell                  r_fill, n_fill;
    t_letter                r_walk, n_walk;
    logic                   r_pend, n_pend;
    t_letter                r_pend_val, n_pend_val;
    t_letter                r_let_a, n_let_a;
    t_letter                r_let_b, n_let_b;
    t_cell_pair             r_pos, n_pos;
    logic                   r_out_valid, n_out_valid;
    logic [6:0]             r_out_letter, n_out_letter;
    logic                   r_out_last, n_out_last;

    t_fold      fold;
    logic       accept;
    logic       full;
    logic       place_req;
    t_letter    place_idx;
    logic       place_en;
    t_letter    pos_raddr;
    t_cell      pos_rdata;
    t_cell      sq_raddr;
    t_letter    sq_rdata;
    t_cell_pair cells;
    logic [6:0] sq_ascii;

    assign fold     = fold_letter(i_letter);
    assign accept   = i_in_valid && o_in_ready;
    assign full     = (r_fill == t_cell'(SQ_CELLS));
    assign place_en = place_req && !r_used[place_idx] && !full;
    assign sq_ascii = 7'(ASCII_UA) + {2'b00, sq_rdata};

    pf_ram #(.Width(LETTER_W), .Depth(SQ_CELLS)) u_sq_ram (
        .i_clk   (i_clk),
        .i_we    (place_en),
        .i_waddr (r_fill),
        .i_wdata (place_idx),
        .i_raddr (sq_raddr),
        .o_rdata (sq_rdata)
    );

    pf_ram #(.Width(LETTER_W), .Depth(NUM_LETTERS)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (place_en),
        .i_waddr (place_idx),
        .i_wdata (r_fill),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    pf_rule u_rule (
        .i_pos  (r_pos),
        .o_cell (cells)
    );

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_fill       = r_fill;
        n_walk       = r_walk;
        n_pend       = r_pend;
        n_pend_val   = r_pend_val;
        n_let_a      = r_let_a;
        n_let_b      = r_let_b;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid;
        n_out_letter = r_out_letter;
        n_out_last   = r_out_last;
        place_req    = 1'b0;
        place_idx    = fold.idx;
        pos_raddr    = r_let_a;
        sq_raddr     = cells.a;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        KIND_KEY: begin
                            place_req = fold.ok;
                        end
                        KIND_KEY_END: begin
                            n_walk  = '0;
                            n_state = S_FILL;
                        end
                        KIND_TEXT: begin
                            if (full && fold.ok) begin
                                if (!r_pend) begin
                                    n_pend     = 1'b1;
                                    n_pend_val = fold.idx;
                                end else begin
                                    n_let_a = r_pend_val;
                                    n_state = S_RDA;
                                    if (fold.idx == r_pend_val) begin
                                        // doubled letter: second copy stays pending
                                        n_let_b = LETTER_X;
                                    end else begin
                                        n_let_b    = fold.idx;
                                        n_pend     = 1'b0;
                                        n_pend_val = '0;
                                    end
                                end
                            end
                        end
                        KIND_TEXT_END: begin
                            if (full && r_pend) begin
                                n_let_a    = r_pend_val;
                                n_let_b    = LETTER_X;
                                n_pend     = 1'b0;
                                n_pend_val = '0;
                                n_state    = S_RDA;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                place_req = 1'b1;
                place_idx = r_walk;
                n_walk    = r_walk + 5'd1;
                if (r_walk == t_letter'(NUM_LETTERS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_RDA: begin
                pos_raddr = r_let_a;
                n_state   = S_RDB;
            end
            S_RDB: begin
                pos_raddr = r_let_b;
                n_pos.a   = pos_rdata;
                n_state   = S_MAP;
            end
            S_MAP: begin
                pos_raddr = r_let_b;
                n_pos.b   = pos_rdata;
                n_state   = S_SQ1;
            end
            S_SQ1: begin
                sq_raddr = cells.a;
                n_state  = S_SQ2;
            end
            S_SQ2: begin
                sq_raddr     = cells.b;
                n_out_letter = sq_ascii;
                n_out_last   = 1'b0;
                n_out_valid  = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // square read of the second cell stays on the port
                sq_raddr = cells.b;
                if (i_out_ready) begin
                    if (!r_out_last) begin
                        n_out_letter = sq_ascii;
                        n_out_last   = 1'b1;
                    end else begin
                        n_out_valid = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (place_en) begin
            n_used[place_idx] = 1'b1;
            n_fill            = r_fill + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= NUM_LETTERS'(1) << LETTER_J;
            r_fill      <= '0;
            r_walk      <= '0;
            r_pend      <= 1'b0;
            r_pend_val  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_fill      <= n_fill;
            r_walk      <= n_walk;
            r_pend      <= n_pend;
            r_pend_val  <= n_pend_val;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_let_a      <= n_let_a;
        r_let_b      <= n_let_b;
        r_pos        <= n_pos;
        r_out_letter <= n_out_letter;
        r_out_last   <= n_out_last;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cipher_letter = r_out_letter;
    assign o_last          = r_out_last;

endmodule

### design/pf_chk.sv
module pf_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input logic [6:0]    o_cipher_letter,
    input logic          o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cipher_letter)
            && $stable(o_last))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cipher_letter >= 7'd65 && o_cipher_letter <= 7'd90)
        else $error("cipher letter out of range");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("request taken while a result is pending");

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid && o_last)
        else $error("second letter of pair missing");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last |=> o_in_ready && !o_out_valid)
        else $error("not idle after pair");

endmodule

bind playfair_cipher_encrypt_top pf_chk u_pf_chk (.*);
